// File: rtl/wait_state_and_prescaled_timers_assert.svh
// assertion helpers shared by the wait state and timer block
`ifndef WAIT_STATE_AND_PRESCALED_TIMERS_ASSERT_SVH
`define WAIT_STATE_AND_PRESCALED_TIMERS_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define WST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define WST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wst_pkg.sv
package wst_pkg;

  // prescaler and counter widths
  localparam int unsigned PrescW  = 8;
  localparam int unsigned EdgeW   = 8;
  localparam int unsigned OutCntW = 4;
  localparam int unsigned NumTimers = 3;

  // default prescaler periods
  localparam int unsigned SlowPeriodDef = 192;
  localparam int unsigned FastPeriodDef = 24;

  // address decode constants
  localparam logic [15:0] IoPageMask = 16'hfff0;
  localparam logic [15:0] IoPageBase = 16'h00f0;
  localparam logic [15:0] BootRomBase = 16'hffc0;

  // configuration register indexes
  localparam int unsigned PaddrW = 5;
  localparam logic [2:0] RegExtWait   = 3'd0;
  localparam logic [2:0] RegIntWait   = 3'd1;
  localparam logic [2:0] RegBootRom   = 3'd2;
  localparam logic [2:0] RegTmrRun    = 3'd3;
  localparam logic [2:0] RegTmrHalt   = 3'd4;
  localparam logic [2:0] RegTmrEnable = 3'd5;
  localparam logic [2:0] RegTmrTarget = 3'd6;

  typedef struct packed {
    logic        is_access;
    logic [15:0] address;
  } wst_in_t;

  typedef struct packed {
    logic [4:0] cycles_used;
    logic [4:0] timer_ticks;
    logic [3:0] count_zero;
    logic [3:0] count_one;
    logic [3:0] count_two;
  } wst_out_t;

  typedef struct packed {
    logic [1:0]  external_wait;
    logic [1:0]  internal_wait;
    logic        boot_rom_enable;
    logic        timers_run;
    logic        timers_halt;
    logic [2:0]  timer_enables;
    logic [23:0] timer_targets;
  } wst_cfg_t;

  // processor cycles per wait setting
  function automatic logic [4:0] cycles_of(input logic [1:0] sel);
    logic [4:0] r;
    unique case (sel)
      2'd0: r = 5'd2;
      2'd1: r = 5'd4;
      2'd2: r = 5'd10;
      default: r = 5'd20;
    endcase
    return r;
  endfunction

  // timer ticks per wait setting
  function automatic logic [4:0] ticks_of(input logic [1:0] sel);
    logic [4:0] r;
    unique case (sel)
      2'd0: r = 5'd2;
      2'd1: r = 5'd4;
      2'd2: r = 5'd8;
      default: r = 5'd16;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wst_regs.sv
module wst_regs import wst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output wst_cfg_t          cfg_o
);

  wst_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PaddrW-1:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegExtWait:   cfg_d.external_wait   = pwdata[1:0];
        RegIntWait:   cfg_d.internal_wait   = pwdata[1:0];
        RegBootRom:   cfg_d.boot_rom_enable = pwdata[0];
        RegTmrRun:    cfg_d.timers_run      = pwdata[0];
        RegTmrHalt:   cfg_d.timers_halt     = pwdata[0];
        RegTmrEnable: cfg_d.timer_enables   = pwdata[2:0];
        RegTmrTarget: cfg_d.timer_targets   = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{external_wait: 2'd0, internal_wait: 2'd0, boot_rom_enable: 1'b1,
                 timers_run: 1'b1, timers_halt: 1'b0, timer_enables: 3'd0,
                 timer_targets: 24'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      RegExtWait:   prdata = {30'd0, cfg_q.external_wait};
      RegIntWait:   prdata = {30'd0, cfg_q.internal_wait};
      RegBootRom:   prdata = {31'd0, cfg_q.boot_rom_enable};
      RegTmrRun:    prdata = {31'd0, cfg_q.timers_run};
      RegTmrHalt:   prdata = {31'd0, cfg_q.timers_halt};
      RegTmrEnable: prdata = {29'd0, cfg_q.timer_enables};
      RegTmrTarget: prdata = {8'd0, cfg_q.timer_targets};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/wst_wait_sel.sv
module wst_wait_sel import wst_pkg::*; (
  input  wst_in_t    item_i,
  input  wst_cfg_t   cfg_i,
  output logic [4:0] cycles_o,
  output logic [4:0] ticks_o
);

  logic       io_hit;
  logic       rom_hit;
  logic [1:0] sel;

  // internal timing for idle cycles, the i/o page and the mapped boot rom
  assign io_hit  = (item_i.address & IoPageMask) == IoPageBase;
  assign rom_hit = (item_i.address >= BootRomBase) & cfg_i.boot_rom_enable;

  always_comb begin
    priority if (!item_i.is_access) begin
      sel = cfg_i.internal_wait;
    end else if (io_hit || rom_hit) begin
      sel = cfg_i.internal_wait;
    end else begin
      sel = cfg_i.external_wait;
    end
  end

  assign cycles_o = cycles_of(sel);
  assign ticks_o  = ticks_of(sel);

endmodule

// File: rtl/wst_timer.sv
module wst_timer import wst_pkg::*; #(
  parameter int unsigned PERIOD = SlowPeriodDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [4:0]         ticks_i,
  input  logic               run_i,
  input  logic               halt_i,
  input  logic               enable_i,
  input  logic [EdgeW-1:0]   target_i,
  output logic [OutCntW-1:0] count_next_o
);

  localparam logic [PrescW:0] PeriodV = (PrescW+1)'(PERIOD);

  logic [PrescW-1:0]  presc_q, presc_d;
  logic               phase_q, phase_d;
  logic               gated_q, gated_d;
  logic [EdgeW-1:0]   edge_q, edge_d;
  logic [OutCntW-1:0] out_q, out_d;

  logic [PrescW:0]    sum;
  logic               ovf;
  logic               line_new;
  logic               bump;
  logic [EdgeW-1:0]   edge_inc;
  logic               hit;

  // prescaler: at most one overflow per step since ticks stay below the period
  assign sum = {1'b0, presc_q} + {{(PrescW-4){1'b0}}, ticks_i};
  assign ovf = sum >= PeriodV;

  // gated phase line and falling edge detect
  assign line_new = (phase_q ^ ovf) & run_i & ~halt_i;
  assign bump     = ovf & gated_q & ~line_new & enable_i;
  assign edge_inc = edge_q + 1'b1;
  assign hit      = edge_inc == target_i;

  always_comb begin
    presc_d = presc_q;
    phase_d = phase_q;
    gated_d = gated_q;
    edge_d  = edge_q;
    out_d   = out_q;
    if (step_i) begin
      presc_d = ovf ? PrescW'(sum - PeriodV) : PrescW'(sum);
      phase_d = phase_q ^ ovf;
      if (ovf) begin
        gated_d = line_new;
      end
      if (bump) begin
        edge_d = hit ? '0 : edge_inc;
        if (hit) begin
          out_d = out_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      phase_q <= 1'b0;
      gated_q <= 1'b0;
      edge_q  <= '0;
      out_q   <= '0;
    end else begin
      presc_q <= presc_d;
      phase_q <= phase_d;
      gated_q <= gated_d;
      edge_q  <= edge_d;
      out_q   <= out_d;
    end
  end

  assign count_next_o = out_d;

endmodule

// File: rtl/wait_state_and_prescaled_timers.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_data_i  (is_access, address)
// out       output     out_valid_o / out_stall_i out_data_o (cycles, ticks, counts)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one bus cycle per clock while no stall holds it; the input register loads on the
// transfer in and the result register when the item moves on, which a held result
// register can delay; timers update on the move between them
// reset clears the timers and loads the register defaults, no clearing pass
// out_stall_i holds the result register; in_stall_o rises only when the input
// register is full and cannot move into a held result register
module wait_state_and_prescaled_timers import wst_pkg::*; #(
  parameter int unsigned SLOW_PERIOD = SlowPeriodDef,
  parameter int unsigned FAST_PERIOD = FastPeriodDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wst_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wst_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  `include "wait_state_and_prescaled_timers_assert.svh"

  wst_cfg_t           cfg;
  logic               s1_valid_q, s1_valid_d;
  wst_in_t            s1_data_q;
  logic               out_valid_q, out_valid_d;
  wst_out_t           out_data_q;
  logic               advance;
  logic               load;
  logic [4:0]         cycles;
  logic [4:0]         ticks;
  logic [OutCntW-1:0] count_next [NumTimers];

  wst_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  // handshake between input and result registers
  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign load       = in_valid_i & ~in_stall_o;

  assign s1_valid_d  = load | (s1_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_data_q <= in_data_i;
    end
  end

  wst_wait_sel u_wait_sel (
    .item_i   (s1_data_q),
    .cfg_i    (cfg),
    .cycles_o (cycles),
    .ticks_o  (ticks)
  );

  // three prescaled timers, the last one on the fast period
  for (genvar i = 0; i < NumTimers; i++) begin : g_timer
    wst_timer #(
      .PERIOD ((i == NumTimers - 1) ? FAST_PERIOD : SLOW_PERIOD)
    ) u_timer (
      .clk_i,
      .rst_ni,
      .step_i       (advance),
      .ticks_i      (ticks),
      .run_i        (cfg.timers_run),
      .halt_i       (cfg.timers_halt),
      .enable_i     (cfg.timer_enables[i]),
      .target_i     (cfg.timer_targets[EdgeW*i +: EdgeW]),
      .count_next_o (count_next[i])
    );
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.cycles_used <= cycles;
      out_data_q.timer_ticks <= ticks;
      out_data_q.count_zero  <= count_next[0];
      out_data_q.count_one   <= count_next[1];
      out_data_q.count_two   <= count_next[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `WST_ASSERT_IMPL(a_cycles_ticks_pair, out_valid_o,
    (out_data_o.cycles_used == 5'd2 && out_data_o.timer_ticks == 5'd2) ||
    (out_data_o.cycles_used == 5'd4 && out_data_o.timer_ticks == 5'd4) ||
    (out_data_o.cycles_used == 5'd10 && out_data_o.timer_ticks == 5'd8) ||
    (out_data_o.cycles_used == 5'd20 && out_data_o.timer_ticks == 5'd16),
    "result cycles and ticks disagree")
  `WST_ASSERT_NEXT(a_no_dup_result, out_valid_o && !out_stall_i && !s1_valid_q,
    !out_valid_o, "result repeated after transfer")
  `WST_ASSERT_NEXT(a_advance_fills, advance, out_valid_o,
    "item moved but no result held")
  `WST_ASSERT_IMPL(a_stall_only_full, in_stall_o, s1_valid_q && out_valid_o && out_stall_i,
    "input stalled without a full pipeline")

endmodule
